// ----- rtl/core/i2cmts_pkg.sv -----
// Package of the I2C master transfer sequencer: request and status codes,
// controller status codes and configuration register indexes. No dependencies.
package i2cmts_pkg;

    // Request kinds carried by one input beat.
    typedef enum logic [1:0] {
        REQ_BUF_WRITE = 2'd0,
        REQ_START     = 2'd1,
        REQ_EVENT     = 2'd2,
        REQ_BUF_READ  = 2'd3
    } t_req;

    // Transfer status as reported on every result beat.
    typedef enum logic [1:0] {
        ST_BUSY    = 2'd0,
        ST_OK      = 2'd1,
        ST_PROTO   = 2'd2,
        ST_TIMEOUT = 2'd3
    } t_status;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_DEV_ADDR = 2'd0,
        CFG_DIR      = 2'd1,
        CFG_LEN      = 2'd2
    } t_cfg_reg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Controller status codes.
    localparam logic [7:0] SC_START_SENT   = 8'h08;
    localparam logic [7:0] SC_RSTART_SENT  = 8'h10;
    localparam logic [7:0] SC_SLAW_ACK     = 8'h18;
    localparam logic [7:0] SC_SLAW_NACK    = 8'h20;
    localparam logic [7:0] SC_DATA_TX_ACK  = 8'h28;
    localparam logic [7:0] SC_SLAR_ACK     = 8'h40;
    localparam logic [7:0] SC_DATA_RX_ACK  = 8'h50;
    localparam logic [7:0] SC_DATA_RX_NACK = 8'h58;
    localparam logic [7:0] SC_BUS_RELEASED = 8'hF8;

    // Read/write bit of the address byte.
    localparam logic [7:0] SLA_READ_BIT = 8'h01;

endpackage

// ----- rtl/core/i2c_master_transfer_sequencer.sv -----
// Top level of the I2C master transfer sequencer: request decode, byte index,
// transfer status and the result register. Uses i2cmts_pkg and i2cmts_ram.
//
//   Channel   Direction  Handshake                Payload
//   in        inbound    i_in_valid / o_in_stall  req, buffer index/byte, code, timeout, rx
//   out       outbound   o_out_valid / i_out_stall send, ctrl bits, trigger, status, byte
//   cfg       inbound    i_cfg_valid / o_cfg_ready register index and write data
//
// Each request gives exactly one result beat. The accepting edge loads the
// request stage and starts the buffer RAM read (its registered read port sets
// this); the beat is decided and loaded into the result register when the stage
// moves on. A new beat is accepted every cycle unless the request stage is full
// and held by a stalled output. Reset (synchronous, active low) clears the byte
// index, the status to busy and the registers to address 0, write direction,
// length 1; the buffer itself is not cleared. While the output is stalled the
// request stage holds its beat and the input is stalled only once that stage is full.
module i2c_master_transfer_sequencer
    import i2cmts_pkg::*;
#(
    parameter int BUF_DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_req_type,
    input  logic [3:0]            i_buffer_index_in,
    input  logic [7:0]            i_buffer_byte_in,
    input  logic [7:0]            i_status_code,
    input  logic                  i_timeout_flag,
    input  logic [7:0]            i_received_byte,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_send_valid,
    output logic [7:0]            o_send_byte,
    output logic                  o_ctrl_valid,
    output logic                  o_ctrl_start,
    output logic                  o_ctrl_stop,
    output logic                  o_ctrl_ack,
    output logic                  o_trigger,
    output logic [1:0]            o_transfer_status,
    output logic [7:0]            o_buffer_byte_out,
    // configuration channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Address width of the buffer, width of the byte index (which may reach
    // BUF_DEPTH itself) and a common width for all index comparisons.
    localparam int AW  = $clog2(BUF_DEPTH);
    localparam int IXW = $clog2(BUF_DEPTH + 1);
    localparam int CW  = (IXW > 5) ? IXW : 5;

    localparam logic [CW-1:0]  DEPTH_CW  = CW'(BUF_DEPTH);
    localparam logic [IXW-1:0] DEPTH_IX  = IXW'(BUF_DEPTH);

    // ---------------------------------------------------------------------
    // Configuration registers. The user writes only while the block is idle; not enforced.
    // ---------------------------------------------------------------------
    logic [6:0] r_dev_addr;
    logic       r_dir;
    logic [4:0] r_len;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= 7'd0;
            r_dir      <= 1'b0;
            r_len      <= 5'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_DEV_ADDR: r_dev_addr <= i_cfg_data[6:0];
                CFG_DIR:      r_dir      <= i_cfg_data[0];
                CFG_LEN:      r_len      <= i_cfg_data[4:0];
                default:      ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Request stage: holds one accepted beat while its buffer read lands.
    // ---------------------------------------------------------------------
    logic        r_s1_valid;
    t_req        r_s1_req;
    logic [3:0]  r_s1_bidx;
    logic [7:0]  r_s1_bbyte;
    logic [7:0]  r_s1_code;
    logic        r_s1_tmo;
    logic [7:0]  r_s1_rx;
    logic        r_s1_oor;
    logic        r_s1_fwd_hit;
    logic [7:0]  r_s1_fwd_data;

    logic        r_out_valid;
    logic        s1_move;
    logic        in_accept;

    // The stage advances whenever the result register is free or being taken.
    assign s1_move    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_move;
    assign in_accept  = i_in_valid && !o_in_stall;

    // ---------------------------------------------------------------------
    // Sequencing state.
    // ---------------------------------------------------------------------
    logic [IXW-1:0] r_byte_index;
    logic [IXW-1:0] n_byte_index;
    t_status        r_status;
    t_status        n_status;

    // Buffer write port, driven by the beat leaving the request stage.
    logic           ram_wr_en;
    logic [CW-1:0]  wr_cw;
    logic [7:0]     wr_data;

    // Buffer read port, driven by the beat being accepted. The byte index it
    // uses is the one left behind by the beat that leaves in the same cycle.
    logic [IXW-1:0] cur_idx;
    logic [CW-1:0]  rd_cw;
    logic           rd_oor;
    logic [7:0]     ram_rd_data;
    logic           fwd_hit;

    assign cur_idx = s1_move ? n_byte_index : r_byte_index;
    assign rd_cw   = (t_req'(i_req_type) == REQ_BUF_READ) ? CW'(i_buffer_index_in)
                                                           : CW'(cur_idx);
    assign rd_oor  = (rd_cw >= DEPTH_CW);
    // A write to the same entry in the same cycle is caught here, since the
    // RAM returns the old contents in that case.
    assign fwd_hit = ram_wr_en && (wr_cw == rd_cw);

    i2cmts_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_buffer (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (wr_cw[AW-1:0]),
        .i_wr_data (wr_data),
        .i_rd_en   (in_accept),
        .i_rd_addr (rd_cw[AW-1:0]),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_req      <= t_req'(i_req_type);
            r_s1_bidx     <= i_buffer_index_in;
            r_s1_bbyte    <= i_buffer_byte_in;
            r_s1_code     <= i_status_code;
            r_s1_tmo      <= i_timeout_flag;
            r_s1_rx       <= i_received_byte;
            r_s1_oor      <= rd_oor;
            r_s1_fwd_hit  <= fwd_hit;
            r_s1_fwd_data <= wr_data;
        end
    end

    // ---------------------------------------------------------------------
    // Decision logic for the beat in the request stage.
    // ---------------------------------------------------------------------
    logic [7:0]     s1_rd_byte;
    logic [CW-1:0]  len_cw;
    logic [CW-1:0]  eff_len;
    logic [CW-1:0]  end_mark;
    logic [IXW-1:0] adv_idx;
    logic           idx_below_end;
    logic           adv_below_end;
    logic           wr_req;
    logic           wr_in_range;

    logic           n_send_valid;
    logic [7:0]     n_send_byte;
    logic           n_ctrl_valid;
    logic           n_ctrl_start;
    logic           n_ctrl_stop;
    logic           n_ctrl_ack;
    logic           n_trigger;
    logic [7:0]     n_buf_out;

    assign s1_rd_byte = r_s1_oor     ? 8'd0 :
                        r_s1_fwd_hit ? r_s1_fwd_data : ram_rd_data;

    // Length is clamped to 1..BUF_DEPTH; a read stops acking one byte early.
    assign len_cw   = CW'(r_len);
    assign eff_len  = (len_cw == '0)      ? CW'(1)   :
                      (len_cw > DEPTH_CW) ? DEPTH_CW : len_cw;
    assign end_mark = eff_len - CW'(r_dir);

    assign adv_idx       = (r_byte_index < DEPTH_IX) ? r_byte_index + IXW'(1)
                                                     : r_byte_index;
    assign idx_below_end = (CW'(r_byte_index) < end_mark);
    assign adv_below_end = (CW'(adv_idx) < end_mark);

    always_comb begin
        n_byte_index = r_byte_index;
        n_status     = r_status;
        n_send_valid = 1'b0;
        n_send_byte  = 8'd0;
        n_ctrl_valid = 1'b0;
        n_ctrl_start = 1'b0;
        n_ctrl_stop  = 1'b0;
        n_ctrl_ack   = 1'b0;
        n_trigger    = 1'b0;
        n_buf_out    = 8'd0;
        wr_req       = 1'b0;
        wr_cw        = CW'(r_byte_index);
        wr_data      = r_s1_rx;

        case (r_s1_req)
            REQ_BUF_WRITE: begin
                wr_req  = 1'b1;
                wr_cw   = CW'(r_s1_bidx);
                wr_data = r_s1_bbyte;
            end
            REQ_START: begin
                n_byte_index = '0;
                n_status     = ST_BUSY;
                n_ctrl_valid = 1'b1;
                n_ctrl_start = 1'b1;
            end
            REQ_BUF_READ: begin
                n_buf_out = s1_rd_byte;
            end
            REQ_EVENT: begin
                if (r_s1_tmo) begin
                    n_status = ST_TIMEOUT;
                end else begin
                    case (r_s1_code)
                        SC_START_SENT: begin
                            n_send_valid = 1'b1;
                            n_send_byte  = {r_dev_addr, 1'b0};
                            n_trigger    = 1'b1;
                        end
                        SC_RSTART_SENT: begin
                            n_send_valid = 1'b1;
                            n_send_byte  = {r_dev_addr, 1'b0} | SLA_READ_BIT;
                            n_trigger    = 1'b1;
                        end
                        SC_SLAW_ACK: begin
                            n_send_valid = 1'b1;
                            n_send_byte  = s1_rd_byte;
                            n_trigger    = 1'b1;
                            if (!r_dir) begin
                                n_byte_index = adv_idx;
                            end
                        end
                        SC_SLAW_NACK: begin
                            // Address not acknowledged: STOP and try again.
                            n_ctrl_valid = 1'b1;
                            n_ctrl_start = 1'b1;
                            n_ctrl_stop  = 1'b1;
                            n_trigger    = 1'b1;
                        end
                        SC_DATA_TX_ACK: begin
                            n_trigger = 1'b1;
                            if (r_dir) begin
                                n_ctrl_valid = 1'b1;
                                n_ctrl_start = 1'b1;
                            end else if (idx_below_end) begin
                                n_send_valid = 1'b1;
                                n_send_byte  = s1_rd_byte;
                                n_byte_index = adv_idx;
                            end else begin
                                n_ctrl_valid = 1'b1;
                                n_ctrl_stop  = 1'b1;
                                n_status     = ST_OK;
                            end
                        end
                        SC_SLAR_ACK: begin
                            n_ctrl_valid = 1'b1;
                            n_ctrl_ack   = idx_below_end;
                            n_trigger    = 1'b1;
                        end
                        SC_DATA_RX_ACK: begin
                            wr_req       = 1'b1;
                            n_byte_index = adv_idx;
                            n_ctrl_valid = 1'b1;
                            n_ctrl_ack   = adv_below_end;
                            n_trigger    = 1'b1;
                        end
                        SC_DATA_RX_NACK: begin
                            wr_req       = 1'b1;
                            n_ctrl_valid = 1'b1;
                            n_ctrl_stop  = 1'b1;
                            n_trigger    = 1'b1;
                            n_status     = ST_OK;
                        end
                        SC_BUS_RELEASED: begin
                            n_ctrl_valid = 1'b1;
                            n_ctrl_stop  = 1'b1;
                        end
                        default: begin
                            n_status = ST_PROTO;
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

    // Stores past the end of the buffer are dropped.
    assign wr_in_range = (wr_cw < DEPTH_CW);
    assign ram_wr_en   = s1_move && wr_req && wr_in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index <= '0;
            r_status     <= ST_BUSY;
        end else if (s1_move) begin
            r_byte_index <= n_byte_index;
            r_status     <= n_status;
        end
    end

    // ---------------------------------------------------------------------
    // Result register.
    // ---------------------------------------------------------------------
    logic       r_out_send_valid;
    logic [7:0] r_out_send_byte;
    logic       r_out_ctrl_valid;
    logic       r_out_ctrl_start;
    logic       r_out_ctrl_stop;
    logic       r_out_ctrl_ack;
    logic       r_out_trigger;
    t_status    r_out_status;
    logic [7:0] r_out_buf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_send_valid <= n_send_valid;
            r_out_send_byte  <= n_send_byte;
            r_out_ctrl_valid <= n_ctrl_valid;
            r_out_ctrl_start <= n_ctrl_start;
            r_out_ctrl_stop  <= n_ctrl_stop;
            r_out_ctrl_ack   <= n_ctrl_ack;
            r_out_trigger    <= n_trigger;
            r_out_status     <= n_status;
            r_out_buf        <= n_buf_out;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_send_valid      = r_out_send_valid;
    assign o_send_byte       = r_out_send_byte;
    assign o_ctrl_valid      = r_out_ctrl_valid;
    assign o_ctrl_start      = r_out_ctrl_start;
    assign o_ctrl_stop       = r_out_ctrl_stop;
    assign o_ctrl_ack        = r_out_ctrl_ack;
    assign o_trigger         = r_out_trigger;
    assign o_transfer_status = r_out_status;
    assign o_buffer_byte_out = r_out_buf;

    // ---------------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------------
    a_index_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_index <= DEPTH_IX)
        else $error("byte index ran past the buffer depth");

    a_start_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_move && r_s1_req == REQ_START) |=> (r_byte_index == '0 && r_status == ST_BUSY))
        else $error("start request did not rewind the transfer");

    a_timeout_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_move && r_s1_req == REQ_EVENT && r_s1_tmo) |=> (r_out_status == ST_TIMEOUT))
        else $error("timeout event did not report timeout");

    a_fwd_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && ram_wr_en && wr_cw == rd_cw) |=> r_s1_fwd_hit)
        else $error("same-cycle buffer write not forwarded");

    a_no_write_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_move) |-> !ram_wr_en)
        else $error("buffer written by a beat that did not leave the stage");

endmodule

// ----- rtl/core/i2cmts_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package needed.
module i2cmts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Read returns the old contents when the same address is written.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- tb/i2c_master_transfer_sequencer_tb.sv -----
// Self-checking testbench of the I2C master transfer sequencer: directed and random
// request beats against a cycle-free prediction of every result beat.
// Depends on i2cmts_pkg and the i2c_master_transfer_sequencer top level only.
module i2c_master_transfer_sequencer_tb;
    import i2cmts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUF_DEPTH   = 16;
    // Far beyond the slowest correct run: about 1150 beats, each with the longest
    // sender gap and the longest result stall, plus the drains between phases.
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASES      = 14;
    localparam int PHASE_BEATS = 72;

    // One request beat as the block sees it on its input ports.
    typedef struct packed {
        t_req       req;
        logic [3:0] idx;
        logic [7:0] wbyte;
        logic [7:0] code;
        logic       tmo;
        logic [7:0] rx;
    } t_req_beat;

    // One result beat, in the order of the output ports.
    typedef struct packed {
        logic       send_valid;
        logic [7:0] send_byte;
        logic       ctrl_valid;
        logic       ctrl_start;
        logic       ctrl_stop;
        logic       ctrl_ack;
        logic       trigger;
        t_status    status;
        logic [7:0] byte_out;
    } t_step_result;

    // Tracks the sequencer's buffer, byte index, status and registers, works out
    // the result of every accepted request and checks the results in order.
    class t_i2c_step_tracker;
        logic [7:0]   buffer_mem [BUF_DEPTH];
        logic [4:0]   byte_idx;
        t_status      status;
        logic [6:0]   dev_addr;
        logic         dir;
        logic [4:0]   len;
        t_step_result pending_steps [$];
        int           errors;
        int           steps_checked;

        function new();
            foreach (buffer_mem[i]) buffer_mem[i] = 8'h00;
            byte_idx      = '0;
            status        = ST_BUSY;
            dev_addr      = '0;
            dir           = 1'b0;
            len           = 5'd1;
            errors        = 0;
            steps_checked = 0;
        endfunction

        function void write_reg(t_cfg_reg idx, logic [6:0] data);
            case (idx)
                CFG_DEV_ADDR: dev_addr = data;
                CFG_DIR:      dir      = data[0];
                CFG_LEN:      len      = data[4:0];
                default:      ;
            endcase
        endfunction

        // First index that no longer gets data: the length for a write, one less for
        // a read, where the final byte is answered with NACK instead.
        function logic [4:0] end_mark();
            logic [4:0] n;
            n = len;
            if (n < 5'd1) n = 5'd1;
            if (n > BUF_DEPTH) n = 5'(BUF_DEPTH);
            return dir ? n - 5'd1 : n;
        endfunction

        // Past the buffer the index saturates: sends give zero, stores vanish.
        function logic [7:0] get_byte(logic [4:0] i);
            return (i < BUF_DEPTH) ? buffer_mem[i[3:0]] : 8'h00;
        endfunction

        function void put_byte(logic [4:0] i, logic [7:0] v);
            if (i < BUF_DEPTH) buffer_mem[i[3:0]] = v;
        endfunction

        function void advance();
            if (byte_idx < BUF_DEPTH) byte_idx = byte_idx + 5'd1;
        endfunction

        function void accept_request(t_req_beat b);
            t_step_result r;
            r = '0;
            case (b.req)
                REQ_BUF_WRITE: buffer_mem[b.idx] = b.wbyte;
                REQ_START: begin
                    byte_idx     = '0;
                    status       = ST_BUSY;
                    r.ctrl_valid = 1'b1;
                    r.ctrl_start = 1'b1;
                end
                REQ_BUF_READ: r.byte_out = buffer_mem[b.idx];
                default: begin
                    // A timeout overrides whatever status code comes with it.
                    if (b.tmo) begin
                        status = ST_TIMEOUT;
                    end else begin
                        case (b.code)
                            SC_START_SENT: begin
                                r.send_valid = 1'b1;
                                r.send_byte  = {dev_addr, 1'b0};
                                r.trigger    = 1'b1;
                            end
                            SC_RSTART_SENT: begin
                                r.send_valid = 1'b1;
                                r.send_byte  = {dev_addr, 1'b0} | SLA_READ_BIT;
                                r.trigger    = 1'b1;
                            end
                            SC_SLAW_ACK: begin
                                r.send_valid = 1'b1;
                                r.send_byte  = get_byte(byte_idx);
                                r.trigger    = 1'b1;
                                if (!dir) advance();
                            end
                            SC_SLAW_NACK: begin
                                r.ctrl_valid = 1'b1;
                                r.ctrl_start = 1'b1;
                                r.ctrl_stop  = 1'b1;
                                r.trigger    = 1'b1;
                            end
                            SC_DATA_TX_ACK: begin
                                if (dir) begin
                                    r.ctrl_valid = 1'b1;
                                    r.ctrl_start = 1'b1;
                                end else if (byte_idx < end_mark()) begin
                                    r.send_valid = 1'b1;
                                    r.send_byte  = get_byte(byte_idx);
                                    advance();
                                end else begin
                                    r.ctrl_valid = 1'b1;
                                    r.ctrl_stop  = 1'b1;
                                    status       = ST_OK;
                                end
                                r.trigger = 1'b1;
                            end
                            SC_SLAR_ACK: begin
                                r.ctrl_valid = 1'b1;
                                r.ctrl_ack   = (byte_idx < end_mark());
                                r.trigger    = 1'b1;
                            end
                            SC_DATA_RX_ACK: begin
                                put_byte(byte_idx, b.rx);
                                advance();
                                r.ctrl_valid = 1'b1;
                                r.ctrl_ack   = (byte_idx < end_mark());
                                r.trigger    = 1'b1;
                            end
                            SC_DATA_RX_NACK: begin
                                put_byte(byte_idx, b.rx);
                                r.ctrl_valid = 1'b1;
                                r.ctrl_stop  = 1'b1;
                                r.trigger    = 1'b1;
                                status       = ST_OK;
                            end
                            SC_BUS_RELEASED: begin
                                r.ctrl_valid = 1'b1;
                                r.ctrl_stop  = 1'b1;
                            end
                            default: status = ST_PROTO;
                        endcase
                    end
                end
            endcase
            r.status = status;
            pending_steps.push_back(r);
        endfunction

        function void compare_field(string name, logic [7:0] e, logic [7:0] a);
            if (e !== a) begin
                errors++;
                if (errors <= 10)
                    $display("result %0d, %s: expected %0h, got %0h",
                             steps_checked, name, e, a);
            end
        endfunction

        function void check_step(t_step_result got);
            t_step_result want;
            steps_checked++;
            if (pending_steps.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("result %0d arrived with nothing outstanding", steps_checked);
                return;
            end
            want = pending_steps.pop_front();
            compare_field("send_valid", 8'(want.send_valid), 8'(got.send_valid));
            compare_field("send_byte", want.send_byte, got.send_byte);
            compare_field("ctrl_valid", 8'(want.ctrl_valid), 8'(got.ctrl_valid));
            compare_field("ctrl_start", 8'(want.ctrl_start), 8'(got.ctrl_start));
            compare_field("ctrl_stop", 8'(want.ctrl_stop), 8'(got.ctrl_stop));
            compare_field("ctrl_ack", 8'(want.ctrl_ack), 8'(got.ctrl_ack));
            compare_field("trigger", 8'(want.trigger), 8'(got.trigger));
            compare_field("transfer_status", 8'(want.status), 8'(got.status));
            compare_field("buffer_byte_out", want.byte_out, got.byte_out);
        endfunction
    endclass

    // Clock, reset and every input of the block start from known values.
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    t_req_beat             in_beat = '0;
    logic                  out_stall = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic                  o_in_stall;
    logic                  o_out_valid;
    logic                  o_send_valid;
    logic [7:0]            o_send_byte;
    logic                  o_ctrl_valid;
    logic                  o_ctrl_start;
    logic                  o_ctrl_stop;
    logic                  o_ctrl_ack;
    logic                  o_trigger;
    logic [1:0]            o_transfer_status;
    logic [7:0]            o_buffer_byte_out;
    logic                  o_cfg_ready;
    t_step_result          seen_step;

    t_i2c_step_tracker tracker = new();

    // When set, neither side idles: stretches at full rate in both directions.
    bit calm = 1'b0;
    int beats_sent = 0;
    int cycles = 0;
    int stall_run = 0;
    int free_run = 0;

    i2c_master_transfer_sequencer #(
        .BUF_DEPTH(BUF_DEPTH)
    ) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (o_in_stall),
        .i_req_type        (in_beat.req),
        .i_buffer_index_in (in_beat.idx),
        .i_buffer_byte_in  (in_beat.wbyte),
        .i_status_code     (in_beat.code),
        .i_timeout_flag    (in_beat.tmo),
        .i_received_byte   (in_beat.rx),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (out_stall),
        .o_send_valid      (o_send_valid),
        .o_send_byte       (o_send_byte),
        .o_ctrl_valid      (o_ctrl_valid),
        .o_ctrl_start      (o_ctrl_start),
        .o_ctrl_stop       (o_ctrl_stop),
        .o_ctrl_ack        (o_ctrl_ack),
        .o_trigger         (o_trigger),
        .o_transfer_status (o_transfer_status),
        .o_buffer_byte_out (o_buffer_byte_out),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    assign seen_step = {o_send_valid, o_send_byte, o_ctrl_valid, o_ctrl_start, o_ctrl_stop,
                        o_ctrl_ack, o_trigger, o_transfer_status, o_buffer_byte_out};

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Both channels are sampled at the rising edge, before any register of the
    // block updates, so the values seen are the ones that the edge acts on. The
    // request beat is noted before the result is checked, although a result can
    // never belong to a beat accepted at the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && !o_in_stall) tracker.accept_request(in_beat);
            if (o_out_valid && !out_stall) tracker.check_step(seen_step);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timed out after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    // Length of an idle stretch: mostly none or short, now and then long.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // The result side alternates free runs with stalls of random length. Only
    // one assignment to the stall is made at each falling edge.
    always @(negedge i_clk) begin
        if (calm) begin
            out_stall <= 1'b0;
        end else if (stall_run > 0) begin
            out_stall <= 1'b1;
            stall_run--;
        end else if (free_run > 0) begin
            out_stall <= 1'b0;
            free_run--;
        end else begin
            out_stall <= 1'b0;
            stall_run = idle_length();
            free_run  = $urandom_range(1, 12);
        end
    end

    // Every field random, so that fields a request does not use still toggle.
    function automatic t_req_beat rand_beat();
        t_req_beat b;
        b.req   = t_req'(2'($urandom_range(0, 3)));
        b.idx   = 4'($urandom_range(0, 15));
        b.wbyte = 8'($urandom_range(0, 255));
        b.code  = 8'($urandom_range(0, 255));
        b.tmo   = 1'($urandom_range(0, 1));
        b.rx    = 8'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic t_req_beat event_beat(logic [7:0] code);
        t_req_beat b;
        b      = rand_beat();
        b.req  = REQ_EVENT;
        b.code = code;
        b.tmo  = 1'b0;
        return b;
    endfunction

    function automatic t_req_beat start_beat();
        t_req_beat b;
        b     = rand_beat();
        b.req = REQ_START;
        return b;
    endfunction

    // Anything at all; events carry a known code half of the time and a
    // timeout now and then.
    function automatic t_req_beat noise_beat();
        t_req_beat b;
        logic [7:0] known [9];
        known = '{SC_START_SENT, SC_RSTART_SENT, SC_SLAW_ACK, SC_SLAW_NACK, SC_DATA_TX_ACK,
                  SC_SLAR_ACK, SC_DATA_RX_ACK, SC_DATA_RX_NACK, SC_BUS_RELEASED};
        b = rand_beat();
        if ($urandom_range(0, 1)) b.code = known[$urandom_range(0, 8)];
        b.tmo = ($urandom_range(0, 7) == 0);
        return b;
    endfunction

    // Entered and left at a falling edge. The valid is lowered only for a gap,
    // so it is never both lowered and raised in the same time step.
    task automatic drive_request(t_req_beat b);
        int gap;
        gap = idle_length();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge i_clk); while (o_in_stall);
        beats_sent++;
        @(negedge i_clk);
    endtask

    // One step of a well-formed transfer; now and then a stray beat slips in
    // first, or the step itself is spoilt by a timeout or an unknown code.
    task automatic transfer_step(t_req_beat b);
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) drive_request(noise_beat());
        if (r == 97) b.tmo = 1'b1;
        if (r >= 98) b.code = 8'($urandom_range(0, 255));
        drive_request(b);
    endtask

    // A whole transfer as the controller would report it for the present
    // direction and length, with the odd address NACK and retry.
    task automatic run_transfer();
        int n;
        n = int'(tracker.len);
        if (n < 1) n = 1;
        if (n > BUF_DEPTH) n = BUF_DEPTH;
        transfer_step(start_beat());
        transfer_step(event_beat(SC_START_SENT));
        if ($urandom_range(0, 9) == 0) begin
            transfer_step(event_beat(SC_SLAW_NACK));
            transfer_step(event_beat(SC_START_SENT));
        end
        transfer_step(event_beat(SC_SLAW_ACK));
        if (!tracker.dir) begin
            repeat (n) transfer_step(event_beat(SC_DATA_TX_ACK));
        end else begin
            transfer_step(event_beat(SC_DATA_TX_ACK));
            transfer_step(event_beat(SC_RSTART_SENT));
            transfer_step(event_beat(SC_SLAR_ACK));
            repeat (n - 1) transfer_step(event_beat(SC_DATA_RX_ACK));
            transfer_step(event_beat(SC_DATA_RX_NACK));
        end
        if ($urandom_range(0, 1)) transfer_step(event_beat(SC_BUS_RELEASED));
    endtask

    // The sender holds off until every outstanding result has come back.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (tracker.pending_steps.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Leaves the valid high; the caller lowers it after its last write.
    task automatic write_cfg(t_cfg_reg idx, logic [6:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    initial begin
        t_req_beat  b;
        logic [6:0] addr;
        logic       dir;
        logic [4:0] len;
        int         phase_end;
        int         r;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, with the registers at their reset values. The buffer
        // is filled first so that no later read or send finds an unwritten entry.
        for (int i = 0; i < BUF_DEPTH; i++) begin
            b       = rand_beat();
            b.req   = REQ_BUF_WRITE;
            b.idx   = 4'(i);
            b.wbyte = (i == 0) ? 8'h00 : (i == BUF_DEPTH - 1) ? 8'hFF
                                       : 8'($urandom_range(0, 255));
            drive_request(b);
        end
        b = rand_beat();
        b.req = REQ_BUF_READ;
        b.idx = 4'd0;
        drive_request(b);
        b.idx = 4'd15;
        drive_request(b);
        // Write transfer of one byte, ending in STOP and the bus released.
        drive_request(start_beat());
        drive_request(event_beat(SC_START_SENT));
        drive_request(event_beat(SC_SLAW_ACK));
        drive_request(event_beat(SC_DATA_TX_ACK));
        drive_request(event_beat(SC_BUS_RELEASED));
        // Address not acknowledged, then the read-side codes with extreme bytes.
        drive_request(event_beat(SC_SLAW_NACK));
        drive_request(event_beat(SC_RSTART_SENT));
        drive_request(event_beat(SC_SLAR_ACK));
        b = event_beat(SC_DATA_RX_ACK);
        b.rx = 8'hFF;
        drive_request(b);
        b = event_beat(SC_DATA_RX_NACK);
        b.rx = 8'h00;
        drive_request(b);
        // Unknown codes, a timeout that carries a valid code, and a fresh start.
        drive_request(event_beat(8'h00));
        drive_request(event_beat(8'hFF));
        b = event_beat(SC_START_SENT);
        b.tmo = 1'b1;
        drive_request(b);
        drive_request(start_beat());

        // Random part: each phase drains, sets the registers and then runs
        // mostly well-formed transfers, with buffer traffic and noise between.
        for (int p = 0; p < PHASES; p++) begin
            calm = 1'b0;
            wait_idle();
            case (p)
                0: begin addr = 7'h00; dir = 1'b0; len = 5'd1;  end
                1: begin addr = 7'h7F; dir = 1'b1; len = 5'd16; end
                // Lengths outside 1..16 are clamped by the block.
                2: begin addr = 7'h55; dir = 1'b1; len = 5'd0;  end
                3: begin addr = 7'h2A; dir = 1'b0; len = 5'd31; end
                default: begin
                    addr = 7'($urandom_range(0, 127));
                    dir  = 1'($urandom_range(0, 1));
                    len  = ($urandom_range(0, 7) == 0) ? 5'd16 : 5'($urandom_range(1, 6));
                end
            endcase
            write_cfg(CFG_DEV_ADDR, addr);
            write_cfg(CFG_DIR, {6'd0, dir});
            write_cfg(CFG_LEN, {2'd0, len});
            cfg_valid <= 1'b0;
            calm = (p % 4 == 3);
            phase_end = beats_sent + PHASE_BEATS;
            while (beats_sent < phase_end) begin
                r = $urandom_range(0, 9);
                if (r < 8) begin
                    run_transfer();
                end else if (r == 8) begin
                    b = rand_beat();
                    b.req = REQ_BUF_WRITE;
                    drive_request(b);
                end else begin
                    drive_request(noise_beat());
                end
            end
        end

        calm = 1'b0;
        wait_idle();
        repeat (8) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
